// File: rtl/core/lth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lth_pkg
// Shared widths, register map, state and command types for the line /
// triangle hit test.
// ----------------------------------------------------------------------------
package lth_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int DOT_W      = CROSS_W + COORD_BITS;
   localparam int SUM_W      = DOT_W + 2;

   localparam int NUM_REGS   = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] FIRST_DOT_STEP  = 3'd1;
   localparam logic [STEP_W-1:0] LAST_CROSS_STEP = 3'd2;
   localparam logic [STEP_W-1:0] FIRST_SUM_STEP  = 3'd2;
   localparam logic [STEP_W-1:0] LAST_DOT_STEP   = 3'd3;
   localparam logic [STEP_W-1:0] LAST_STEP       = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // edge pair fed to the cross product unit
   typedef enum logic [1:0] {
      PAIR_AB,
      PAIR_BC,
      PAIR_CA
   } pair_type;

   typedef struct packed {
      logic     load;
      logic     cross_en;
      pair_type cross_sel;
      logic     dot_en;
      logic     sum_en;
      logic     finish_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic final_tri;
      logic rsp_busy;
   } dp_status_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

endpackage
`default_nettype wire

// File: rtl/core/line_triangle_hit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_triangle_hit_test
// Tests a configured line against a stream of triangles and reports whether
// any triangle of the mesh was hit.
//
// Set origin and direction over the csr_ APB port while idle. Triangles come
// in on req_ (valid/ready), three vertices each, req_final_triangle on the
// last one of a mesh. Each triangle holds the block through the load cycle
// of its transfer, the run steps in which one cross product unit (six 17x17
// multipliers) and one dot product unit (three 35x16 multipliers) step over
// the edge pairs in turn, and the retire cycle, so the next input transfer is
// taken only after that retire.
// A final triangle puts one rsp_any_hit transfer into the output register at
// its retire and clears the sticky hit flag.
// If the receiver stalls, the block keeps taking triangles; only the retire
// of a further final triangle waits until the pending result is taken.
// Reset clears the registers to zero, the hit flag and the output valid.
// ----------------------------------------------------------------------------
module line_triangle_hit_test import lth_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire coord_type             req_vert_a_x,
   input  wire coord_type             req_vert_a_y,
   input  wire coord_type             req_vert_a_z,
   input  wire coord_type             req_vert_b_x,
   input  wire coord_type             req_vert_b_y,
   input  wire coord_type             req_vert_b_z,
   input  wire coord_type             req_vert_c_x,
   input  wire coord_type             req_vert_c_y,
   input  wire coord_type             req_vert_c_z,
   input  wire logic                  req_final_triangle,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_any_hit
);

   coord_type     origin [3];
   coord_type     dir [3];
   coord_type     vert [3][3];
   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign vert[0][0] = req_vert_a_x;
   assign vert[0][1] = req_vert_a_y;
   assign vert[0][2] = req_vert_a_z;
   assign vert[1][0] = req_vert_b_x;
   assign vert[1][1] = req_vert_b_y;
   assign vert[1][2] = req_vert_b_z;
   assign vert[2][0] = req_vert_c_x;
   assign vert[2][1] = req_vert_c_y;
   assign vert[2][2] = req_vert_c_z;

   lth_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .origin      (origin),
      .dir         (dir)
   );

   lth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lth_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .vert           (vert),
      .final_triangle (req_final_triangle),
      .origin         (origin),
      .dir            (dir),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_any_hit    (rsp_any_hit)
   );

endmodule
`default_nettype wire

// File: rtl/core/lth_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lth_csr
// APB register file holding the line origin and direction.
// ----------------------------------------------------------------------------
module lth_csr import lth_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output coord_type                  origin [3],
   output coord_type                  dir [3]
);

   coord_type                 regs_ff [NUM_REGS];
   logic                      wr_en;
   logic      [REG_IDX_W-1:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en && idx < REG_IDX_W'(NUM_REGS)) begin
         regs_ff[idx] <= csr_pwdata[COORD_BITS-1:0];
      end
   end

   always_comb begin
      case (idx)
         REG_ORIGIN_X: csr_prdata = CSR_DATA_W'(regs_ff[REG_ORIGIN_X]);
         REG_ORIGIN_Y: csr_prdata = CSR_DATA_W'(regs_ff[REG_ORIGIN_Y]);
         REG_ORIGIN_Z: csr_prdata = CSR_DATA_W'(regs_ff[REG_ORIGIN_Z]);
         REG_DIR_X:    csr_prdata = CSR_DATA_W'(regs_ff[REG_DIR_X]);
         REG_DIR_Y:    csr_prdata = CSR_DATA_W'(regs_ff[REG_DIR_Y]);
         REG_DIR_Z:    csr_prdata = CSR_DATA_W'(regs_ff[REG_DIR_Z]);
         default:      csr_prdata = '0;
      endcase
   end

   assign origin[0] = regs_ff[REG_ORIGIN_X];
   assign origin[1] = regs_ff[REG_ORIGIN_Y];
   assign origin[2] = regs_ff[REG_ORIGIN_Z];
   assign dir[0]    = regs_ff[REG_DIR_X];
   assign dir[1]    = regs_ff[REG_DIR_Y];
   assign dir[2]    = regs_ff[REG_DIR_Z];

endmodule
`default_nettype wire

// File: rtl/core/lth_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lth_ctrl
// Sequencer: loads a triangle, steps the cross / dot / sum stages over the
// edge pairs in turn, then retires the triangle into the sticky hit flag.
// ----------------------------------------------------------------------------
module lth_ctrl import lth_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type                state_ff, state_in;
   logic      [STEP_W-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.cross_sel = PAIR_AB;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.cross_en  = step_ff <= LAST_CROSS_STEP;
            cmd.cross_sel = pair_type'(step_ff[1:0]);
            cmd.dot_en    = step_ff >= FIRST_DOT_STEP && step_ff <= LAST_DOT_STEP;
            cmd.sum_en    = step_ff >= FIRST_SUM_STEP;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FINISH: begin
            if (!(status.final_tri && status.rsp_busy)) begin
               cmd.finish_en = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/lth_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lth_datapath
// Translated vertex registers, cross product, dot product and sign stages,
// sticky hit flag and the result register.
// ----------------------------------------------------------------------------
module lth_datapath import lth_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status,
   input  wire coord_type     vert [3][3],
   input  wire logic          final_triangle,
   input  wire coord_type     origin [3],
   input  wire coord_type     dir [3],
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_any_hit
);

   logic signed [DIFF_W-1:0]  vert_ff [3][3];
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [CROSS_W-1:0] cross_in [3];
   logic signed [DOT_W-1:0]   dot_ff [3];
   logic signed [DOT_W-1:0]   dot_in [3];
   logic signed [DIFF_W-1:0]  u [3];
   logic signed [DIFF_W-1:0]  w [3];
   logic signed [PROD_W-1:0]  prod_p [3];
   logic signed [PROD_W-1:0]  prod_n [3];
   logic signed [SUM_W-1:0]   sum;
   logic                      sum_pos;
   logic                      final_ff;
   logic                      any_pos_ff;
   logic                      hit_so_far_ff;
   logic                      hit_now;
   logic                      rsp_valid_ff;
   logic                      rsp_any_hit_ff;

   // edge pair select: (a,b), (b,c), (c,a)
   always_comb begin
      case (cmd.cross_sel)
         PAIR_AB: begin
            u = vert_ff[0];
            w = vert_ff[1];
         end
         PAIR_BC: begin
            u = vert_ff[1];
            w = vert_ff[2];
         end
         PAIR_CA: begin
            u = vert_ff[2];
            w = vert_ff[0];
         end
         default: begin
            u = vert_ff[0];
            w = vert_ff[1];
         end
      endcase
   end

   always_comb begin
      prod_p[0] = PROD_W'(u[1]) * PROD_W'(w[2]);
      prod_n[0] = PROD_W'(u[2]) * PROD_W'(w[1]);
      prod_p[1] = PROD_W'(u[2]) * PROD_W'(w[0]);
      prod_n[1] = PROD_W'(u[0]) * PROD_W'(w[2]);
      prod_p[2] = PROD_W'(u[0]) * PROD_W'(w[1]);
      prod_n[2] = PROD_W'(u[1]) * PROD_W'(w[0]);
      for (int k = 0; k < 3; k++) begin
         cross_in[k] = CROSS_W'(prod_p[k]) - CROSS_W'(prod_n[k]);
         dot_in[k]   = DOT_W'(cross_ff[k]) * DOT_W'(dir[k]);
      end
   end

   assign sum     = SUM_W'(dot_ff[0]) + SUM_W'(dot_ff[1]) + SUM_W'(dot_ff[2]);
   assign sum_pos = !sum[SUM_W-1] && (sum != '0);
   assign hit_now = hit_so_far_ff | ~any_pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
               vert_ff[v][k] <= DIFF_W'(vert[v][k]) - DIFF_W'(origin[k]);
            end
         end
         final_ff <= final_triangle;
      end
      if (cmd.cross_en) begin
         cross_ff <= cross_in;
      end
      if (cmd.dot_en) begin
         dot_ff <= dot_in;
      end
      if (cmd.finish_en && final_ff) begin
         rsp_any_hit_ff <= hit_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_pos_ff    <= 1'b0;
         hit_so_far_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            any_pos_ff <= 1'b0;
         end else if (cmd.sum_en) begin
            any_pos_ff <= any_pos_ff | sum_pos;
         end
         if (cmd.finish_en) begin
            hit_so_far_ff <= final_ff ? 1'b0 : hit_now;
         end
         if (cmd.finish_en && final_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_any_hit      = rsp_any_hit_ff;
   assign status.final_tri = final_ff;
   assign status.rsp_busy  = rsp_valid_ff & ~rsp_ready;

endmodule
`default_nettype wire

// File: tb/line_triangle_hit_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_triangle_hit_test_tb
// Streams meshes of triangles through the line / triangle hit test under
// several line settings written over the csr_ port. A local predictor forms
// the three scalar triple products exactly, keeps the sticky mesh hit flag
// and queues one any_hit value per final triangle; each rsp_ transfer is
// checked against the oldest queued value. Both channels idle at random, the
// receiver holds off once for a long stretch, and the sender drains the block
// between settings.
// ----------------------------------------------------------------------------
module line_triangle_hit_test_tb import lth_pkg::*; ();

   localparam int RESULT_LATENCY  = 7;
   localparam int SETTLE_CYCLES   = 3 * RESULT_LATENCY;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int RUN_LIMIT_NS    = 2_000_000;
   localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN   = -COORD_MAX - 1;

   typedef struct packed {
      logic                 final_tri;
      coord_type [2:0][2:0] vert;       // [vertex][axis]
   } triangle_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   coord_type             req_vert_a_x = '0;
   coord_type             req_vert_a_y = '0;
   coord_type             req_vert_a_z = '0;
   coord_type             req_vert_b_x = '0;
   coord_type             req_vert_b_y = '0;
   coord_type             req_vert_b_z = '0;
   coord_type             req_vert_c_x = '0;
   coord_type             req_vert_c_y = '0;
   coord_type             req_vert_c_z = '0;
   logic                  req_final_triangle = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_any_hit;

   // predictor state
   longint line_origin[3] = '{0, 0, 0};
   longint line_dir[3]    = '{0, 0, 0};
   bit     mesh_hit_flag  = 1'b0;
   bit     any_hit_q[$];

   int error_count     = 0;
   bit sender_gaps_on  = 1'b1;
   bit rsp_stalls_on   = 1'b1;
   int rsp_hold_cycles = 0;
   bit exp_any_hit;

   line_triangle_hit_test dut (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_vert_a_x       (req_vert_a_x),
      .req_vert_a_y       (req_vert_a_y),
      .req_vert_a_z       (req_vert_a_z),
      .req_vert_b_x       (req_vert_b_x),
      .req_vert_b_y       (req_vert_b_y),
      .req_vert_b_z       (req_vert_b_z),
      .req_vert_c_x       (req_vert_c_x),
      .req_vert_c_y       (req_vert_c_y),
      .req_vert_c_z       (req_vert_c_z),
      .req_final_triangle (req_final_triangle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_any_hit        (rsp_any_hit)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("line_triangle_hit_test_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint triple_product(longint ux, longint uy, longint uz,
                                             longint wx, longint wy, longint wz);
      longint cx, cy, cz;
      cx = uy * wz - uz * wy;
      cy = uz * wx - ux * wz;
      cz = ux * wy - uy * wx;
      return cx * line_dir[0] + cy * line_dir[1] + cz * line_dir[2];
   endfunction

   function automatic bit triangle_hit(triangle_type t);
      longint    rel[3][3];
      longint    s_ab, s_bc, s_ca;
      coord_type c;
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            c = t.vert[v][k];
            rel[v][k] = longint'(c) - line_origin[k];
         end
      end
      s_ab = triple_product(rel[0][0], rel[0][1], rel[0][2], rel[1][0], rel[1][1], rel[1][2]);
      s_bc = triple_product(rel[1][0], rel[1][1], rel[1][2], rel[2][0], rel[2][1], rel[2][2]);
      s_ca = triple_product(rel[2][0], rel[2][1], rel[2][2], rel[0][0], rel[0][1], rel[0][2]);
      return !(s_ab > 0 || s_bc > 0 || s_ca > 0);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_type clamp_coord(longint x);
      if (x > COORD_MAX) return coord_type'(COORD_MAX);
      if (x < COORD_MIN) return coord_type'(COORD_MIN);
      return coord_type'(x);
   endfunction

   function automatic coord_type random_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return coord_type'(COORD_MIN);
      if (r == 1) return coord_type'(COORD_MAX);
      return coord_type'($urandom);
   endfunction

   function automatic coord_type random_setting();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return coord_type'(COORD_MIN);
      if (r < 24) return coord_type'(COORD_MAX);
      if (r < 34) return '0;
      if (r < 70) return coord_type'(int'($urandom_range(0, 2047)) - 1024);
      return coord_type'($urandom);
   endfunction

   function automatic longint random_offset(longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // mostly triangles around the line so hits and misses both show up
   function automatic triangle_type random_triangle(bit last);
      triangle_type t;
      int           kind;
      longint       span;
      longint       u, w;
      case ($urandom_range(0, 2))
         0: span = 64;
         1: span = 1024;
         default: span = 8192;
      endcase
      kind = $urandom_range(0, 99);
      for (int k = 0; k < 3; k++) begin
         if (kind < 45) begin
            // centroid on the line
            u = random_offset(span);
            w = random_offset(span);
            t.vert[0][k] = clamp_coord(line_origin[k] + u);
            t.vert[1][k] = clamp_coord(line_origin[k] + w);
            t.vert[2][k] = clamp_coord(line_origin[k] - u - w);
         end else if (kind < 55) begin
            t.vert[0][k] = random_coord();
            t.vert[1][k] = t.vert[0][k];
            t.vert[2][k] = clamp_coord(line_origin[k] + random_offset(span));
         end else if (kind < 75) begin
            for (int v = 0; v < 3; v++)
               t.vert[v][k] = clamp_coord(line_origin[k] + random_offset(span));
         end else begin
            for (int v = 0; v < 3; v++)
               t.vert[v][k] = random_coord();
         end
      end
      t.final_tri = last;
      return t;
   endfunction

   function automatic triangle_type tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, bit last);
      triangle_type t;
      t.vert[0] = {coord_type'(az), coord_type'(ay), coord_type'(ax)};
      t.vert[1] = {coord_type'(bz), coord_type'(by), coord_type'(bx)};
      t.vert[2] = {coord_type'(cz), coord_type'(cy), coord_type'(cx)};
      t.final_tri = last;
      return t;
   endfunction

   // ---------------------------------------------------------------- bus tasks
   task automatic csr_write(int idx, coord_type value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[COORD_BITS-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx >= int'(REG_DIR_X) && idx <= int'(REG_DIR_Z))
         line_dir[idx - int'(REG_DIR_X)] = longint'(value);
      else if (idx >= int'(REG_ORIGIN_X) && idx <= int'(REG_ORIGIN_Z))
         line_origin[idx - int'(REG_ORIGIN_X)] = longint'(value);
      @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (any_hit_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_line(coord_type ox, coord_type oy, coord_type oz,
                            coord_type dx, coord_type dy, coord_type dz);
      wait_results_drained();
      csr_write(int'(REG_ORIGIN_X), ox);
      csr_write(int'(REG_ORIGIN_Y), oy);
      csr_write(int'(REG_ORIGIN_Z), oz);
      csr_write(int'(REG_DIR_X), dx);
      csr_write(int'(REG_DIR_Y), dy);
      csr_write(int'(REG_DIR_Z), dz);
   endtask

   task automatic send_triangle(triangle_type t);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_final_triangle <= t.final_tri;
      req_vert_a_x       <= t.vert[0][0];
      req_vert_a_y       <= t.vert[0][1];
      req_vert_a_z       <= t.vert[0][2];
      req_vert_b_x       <= t.vert[1][0];
      req_vert_b_y       <= t.vert[1][1];
      req_vert_b_z       <= t.vert[1][2];
      req_vert_c_x       <= t.vert[2][0];
      req_vert_c_y       <= t.vert[2][1];
      req_vert_c_z       <= t.vert[2][2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (triangle_hit(t))
         mesh_hit_flag = 1'b1;
      if (t.final_tri) begin
         any_hit_q.push_back(mesh_hit_flag);
         mesh_hit_flag = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin
      int stall_len;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_len = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (rsp_stalls_on && $urandom_range(0, 2) == 0) begin
            stall_len = pick_gap();
         end else begin
            stall_len = 0;
         end
         if (stall_len == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (stall_len - 1) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checker
   task automatic report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (any_hit_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, any_hit=%b", rsp_any_hit));
         end else begin
            exp_any_hit = any_hit_q.pop_front();
            if (rsp_any_hit !== exp_any_hit)
               report_mismatch($sformatf("any_hit got %b exp %b", rsp_any_hit, exp_any_hit));
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // registers at reset: zero direction, so every triangle is hit
   task automatic test_reset_state();
      send_triangle(random_triangle(1'b0));
      send_triangle(random_triangle(1'b0));
      send_triangle(random_triangle(1'b1));
      send_triangle(tri_of(-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, 32767, -32768, 1'b1));
   endtask

   task automatic test_directed_cases();
      load_line(0, 0, 0, 0, 0, 256);
      // both windings around the z axis
      send_triangle(tri_of(256, 0, 0, 0, 256, 0, -256, -256, 0, 1'b1));
      send_triangle(tri_of(256, 0, 0, -256, -256, 0, 0, 256, 0, 1'b1));
      // sticky flag over a mesh, then cleared
      send_triangle(tri_of(256, 0, 0, -256, -256, 0, 0, 256, 0, 1'b0));
      send_triangle(tri_of(256, 0, 0, 0, 256, 0, -256, -256, 0, 1'b0));
      send_triangle(tri_of(256, 0, 0, 0, 256, 0, -256, -256, 0, 1'b1));
      send_triangle(tri_of(256, 0, 0, 0, 256, 0, -256, -256, 0, 1'b0));
      send_triangle(tri_of(256, 0, 0, 0, 256, 0, -256, -256, 0, 1'b1));
      // degenerate triangle, vertex on the line, triangle parallel to the line
      send_triangle(tri_of(77, -5, 9, 77, -5, 9, 77, -5, 9, 1'b1));
      send_triangle(tri_of(0, 0, 0, 0, 256, 0, -256, -256, 0, 1'b1));
      send_triangle(tri_of(256, 0, 0, 256, 0, 256, 256, 256, 0, 1'b1));
      // out-of-range register indexes must not disturb the line
      wait_results_drained();
      csr_write(NUM_REGS, coord_type'($urandom));
      csr_write(NUM_REGS + 1, coord_type'($urandom));
      send_triangle(tri_of(256, 0, 0, -256, -256, 0, 0, 256, 0, 1'b1));
      // full-scale origin and direction
      load_line(-32768, -32768, -32768, 32767, 32767, 32767);
      send_triangle(tri_of(32767, -32768, 32767, -32768, 32767, -32768,
                           32767, 32767, -32768, 1'b1));
      load_line(32767, 32767, 32767, -32768, -32768, -32768);
      send_triangle(tri_of(-32768, -32768, -32768, -32768, 32767, 32767,
                           32767, -32768, 32767, 1'b1));
      // zero direction away from the origin
      load_line(100, -200, 300, 0, 0, 0);
      send_triangle(random_triangle(1'b1));
   endtask

   // receiver holds off while the sender keeps offering final triangles
   task automatic test_output_backpressure();
      load_line(0, 0, 0, 0, 0, 256);
      sender_gaps_on  = 1'b0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      for (int i = 0; i < 16; i++)
         send_triangle(random_triangle(1'b1));
      wait_results_drained();
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_meshes();
      int sent;
      int len;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_line(coord_type'(COORD_MAX), coord_type'(COORD_MAX), coord_type'(COORD_MAX),
                         coord_type'(COORD_MAX), coord_type'(COORD_MAX), coord_type'(COORD_MAX));
            1: load_line(coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MIN),
                         coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MIN));
            default: load_line(random_setting(), random_setting(), random_setting(),
                               random_setting(), random_setting(), random_setting());
         endcase
         sender_gaps_on = (phase % 3 != 0);
         rsp_stalls_on  = (phase % 4 != 1);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0)
               len = $urandom_range(7, 16);
            else
               len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_triangle(random_triangle(i == len - 1));
            sent += len;
            // sender pause until the block is empty
            if (phase == 3 && sent >= ITEMS_PER_PHASE / 2 && sent - len < ITEMS_PER_PHASE / 2)
               wait_results_drained();
         end
      end
      sender_gaps_on = 1'b1;
      rsp_stalls_on  = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_cases();
      test_output_backpressure();
      test_random_meshes();
      wait_results_drained();
      if (error_count == 0) begin
         $display("line_triangle_hit_test_tb passed");
      end else begin
         $display("line_triangle_hit_test_tb failed");
      end
      $finish;
   end

endmodule
